@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

@@ rtl/fpdiv_pkg.sv @@
// Types and constants shared by the binary64 divider.
package fpdiv_pkg;
	localparam int unsigned QSTEPS = 56;
	localparam logic [10:0] EXP_MAX = 11'h7FF;
	localparam logic [12:0] BIAS = 13'd1023;
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
	localparam logic [63:0] INF_BITS = 64'h7FF0000000000000;

	// Data that travels down the row of division cells.
	typedef struct packed {
		logic        vld;
		logic        special;   // result already fixed by a special case
		logic [63:0] spec_val;
		logic        sign;
		logic [12:0] exp;       // signed biased exponent
		logic [53:0] rem;
		logic [52:0] dvs;
		logic [55:0] quo;
	} cell_t;
endpackage

@@ rtl/fpdiv_cell.sv @@
// One restoring division step: compare, subtract, shift.
module fpdiv_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  fpdiv_pkg::cell_t  din,
	output fpdiv_pkg::cell_t  dout
);
	import fpdiv_pkg::*;
	logic        fits;
	logic [53:0] diff;
	cell_t       nxt;
	always_comb begin
		fits = din.rem >= {1'b0, din.dvs};
		diff = fits ? din.rem - {1'b0, din.dvs} : din.rem;
		nxt = din;
		nxt.rem = {diff[52:0], 1'b0};
		nxt.quo = {din.quo[54:0], fits};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

@@ rtl/fpdiv_unpack.sv @@
// Operand classification, special cases and subnormal normalization.
module fpdiv_unpack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output fpdiv_pkg::cell_t  dout
);
	import fpdiv_pkg::*;
	logic        an, bn, ai, bi, az, bz, sign;
	logic [52:0] ma, mb;
	logic [5:0]  la, lb;
	logic [12:0] ea, eb;
	cell_t       nxt;

	function automatic logic [5:0] lzc53(input logic [52:0] v);
		logic [5:0] n;
		n = 6'd53;
		for (int i = 0; i < 53; i++) begin
			if (v[i]) n = 6'(52 - i);
		end
		return n;
	endfunction

	always_comb begin
		an = (a[62:52] == EXP_MAX) && (a[51:0] != '0);
		bn = (b[62:52] == EXP_MAX) && (b[51:0] != '0);
		ai = (a[62:52] == EXP_MAX) && (a[51:0] == '0);
		bi = (b[62:52] == EXP_MAX) && (b[51:0] == '0);
		az = a[62:0] == '0;
		bz = b[62:0] == '0;
		sign = a[63] ^ b[63];
		la = lzc53({1'b0, a[51:0]});
		lb = lzc53({1'b0, b[51:0]});
		if (a[62:52] != '0) begin
			ma = {1'b1, a[51:0]};
			ea = {2'b0, a[62:52]};
		end else begin
			ma = {1'b0, a[51:0]} << la;
			ea = 13'd1 - {7'd0, la};
		end
		if (b[62:52] != '0) begin
			mb = {1'b1, b[51:0]};
			eb = {2'b0, b[62:52]};
		end else begin
			mb = {1'b0, b[51:0]} << lb;
			eb = 13'd1 - {7'd0, lb};
		end
		nxt.vld = vld;
		nxt.special = 1'b1;
		nxt.sign = sign;
		nxt.exp = ea - eb + BIAS;
		nxt.rem = {1'b0, ma};
		nxt.dvs = mb;
		nxt.quo = '0;
		if (an) nxt.spec_val = a | 64'h0008000000000000;
		else if (bn) nxt.spec_val = b | 64'h0008000000000000;
		else if (ai && bi) nxt.spec_val = DEFAULT_NAN;
		else if (ai) nxt.spec_val = {sign, 63'd0} | INF_BITS;
		else if (bi) nxt.spec_val = {sign, 63'd0};
		else if (az && bz) nxt.spec_val = DEFAULT_NAN;
		else if (az) nxt.spec_val = {sign, 63'd0};
		else if (bz) nxt.spec_val = {sign, 63'd0} | INF_BITS;
		else begin
			nxt.spec_val = '0;
			nxt.special = 1'b0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

@@ rtl/fpdiv_round.sv @@
// Normalize, denormalize, round and pack the quotient.
module fpdiv_round (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  fpdiv_pkg::cell_t  din,
	output logic              vld,
	output logic [63:0]       res
);
	import fpdiv_pkg::*;
	logic [55:0] w, wd;
	logic [12:0] e, s;
	logic [53:0] m;
	logic [55:0] lost_mask;
	logic        up;
	logic [63:0] r;

	function automatic logic [53:0] rne(input logic [55:0] x);
		logic [52:0] mm;
		mm = x[55:3];
		if (x[2:0] > 3'd4 || (x[2:0] == 3'd4 && mm[0])) return {1'b0, mm} + 54'd1;
		return {1'b0, mm};
	endfunction

	always_comb begin
		w = din.quo | {55'd0, din.rem != '0};
		e = din.exp;
		if (!w[55]) begin
			w = {w[54:0], 1'b0};
			e = e - 13'd1;
		end
		s = 13'd1 - e;
		lost_mask = '0;
		wd = '0;
		m = '0;
		up = 1'b0;
		if (din.special) begin
			r = din.spec_val;
		end else if (!e[12] && e >= 13'd2047) begin
			r = {din.sign, 63'd0} | INF_BITS;
		end else if (!e[12] && e != '0) begin
			m = rne(w);
			up = m[53];
			if (up && e == 13'd2046) r = {din.sign, 63'd0} | INF_BITS;
			else if (up) r = {din.sign, 11'(e + 13'd1), m[52:1]};
			else r = {din.sign, e[10:0], m[51:0]};
		end else begin
			if (s >= 13'd63) begin
				wd = 56'd1;
			end else begin
				lost_mask = (56'd1 << s[5:0]) - 56'd1;
				wd = (w >> s[5:0]) | {55'd0, (w & lost_mask) != '0};
			end
			m = rne(wd);
			r = {din.sign, 9'd0, m};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= din.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) res <= r;
	end
endmodule

@@ rtl/fp64_divider.sv @@
// Top level of the pipelined binary64 divider.
//
// IEEE 754 binary64 division, round to nearest even, gradual underflow.
// Input channel s_axis_*: tdata carries dividend (bits 63:0) and divisor
// (bits 127:64). Output channel m_axis_*: tdata carries the quotient.
// An item is accepted when tvalid and tready are both high.
// Structure: one unpack stage, a row of 56 division cells (one quotient
// bit per cell), one round stage. Throughput is one item per cycle
// while the receiver does not stall the output.
// The whole pipeline advances together: when the receiver stalls with a
// result in the output register, every stage holds and s_axis_tready
// drops, so no item is lost or repeated. With the output empty, or taken
// in the same cycle, the pipe keeps moving; empty slots travel with it.
// Reset (arst_n low) clears the unpack and cell registers and the output
// valid flag at once; the output data register is not reset.
// After reset s_axis_tready is high, so the block is ready to accept an item.
module fp64_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,   // dividend [63:0], divisor [127:64]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata    // quotient [63:0]
);
	import fpdiv_pkg::*;

	logic  adv;
	cell_t row [QSTEPS+1];

	// Advance when the output register is empty or being drained.
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	fpdiv_unpack u_unpack (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.vld(s_axis_tvalid),
		.a(s_axis_tdata[63:0]), .b(s_axis_tdata[127:64]),
		.dout(row[0])
	);

	// One quotient bit per cell.
	for (genvar g = 0; g < QSTEPS; g++) begin : g_cell
		fpdiv_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.din(row[g]), .dout(row[g+1])
		);
	end

	fpdiv_round u_round (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din(row[QSTEPS]),
		.vld(m_axis_tvalid), .res(m_axis_tdata)
	);

`include "assert_macros.svh"
	// A stalled result must stay.
	`ASSERT_IMPL(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "result dropped while stalled")
	// Ready follows the output register and the receiver's ready.
	`ASSERT_CLK(a_rdy, clk, arst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
	// Last cell valid reaches the output on advance.
	`ASSERT_IMPL(a_flow, clk, arst_n, adv && row[QSTEPS].vld, ##1 m_axis_tvalid, "result lost at output")
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the pipelined binary64 divider.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8000000000000;
	localparam logic [63:0] INF_PATTERN  = 64'h7FF0000000000000;
	localparam logic [63:0] QUIET_MASK   = 64'h0008000000000000;
	localparam logic [63:0] FRAC_BITS    = 64'h000FFFFFFFFFFFFF;
	localparam int          PIPE_DEPTH   = 58;
	localparam longint      CYCLE_LIMIT  = 400000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [127:0]  s_axis_tdata = '0;   // dividend [63:0], divisor [127:64]
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [63:0]   m_axis_tdata;        // quotient [63:0]

	logic [63:0]   quotient_queue[$];
	int            error_count = 0;
	longint        cycle_count = 0;
	bit            send_idles = 1'b1;
	bit            recv_idles = 1'b1;

	fp64_divider dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Drop three guard bits, rounding to nearest even.
	function automatic logic [63:0] round_even(logic [63:0] w);
		logic [63:0] m;
		m = w >> 3;
		if (w[2:0] > 3'd4 || (w[2:0] == 3'd4 && m[0])) m++;
		return m;
	endfunction

	// Predict one quotient bit for bit: special cases first, then long division.
	function automatic logic [63:0] divide_pattern(logic [63:0] a, logic [63:0] b);
		logic [63:0] sgn, ma, mb, q, r, w, m, lost;
		int          ea, eb, e, s;
		bit          an, bn, ai, bi, az, bz;
		sgn = {a[63] ^ b[63], 63'b0};
		an = a[62:52] == 11'h7FF && a[51:0] != 0;
		bn = b[62:52] == 11'h7FF && b[51:0] != 0;
		ai = a[62:52] == 11'h7FF && a[51:0] == 0;
		bi = b[62:52] == 11'h7FF && b[51:0] == 0;
		az = a[62:0] == 0;
		bz = b[62:0] == 0;
		if (an) return a | QUIET_MASK;
		if (bn) return b | QUIET_MASK;
		if (ai && bi) return QNAN_DEFAULT;
		if (ai) return sgn | INF_PATTERN;
		if (bi) return sgn;
		if (az && bz) return QNAN_DEFAULT;
		if (az) return sgn;
		if (bz) return sgn | INF_PATTERN;
		// normalize subnormals so bit 52 is set
		ma = a & FRAC_BITS; ea = int'(a[62:52]);
		if (ea != 0) ma[52] = 1'b1;
		else begin
			ea = 1;
			while (!ma[52]) begin ma = ma << 1; ea--; end
		end
		mb = b & FRAC_BITS; eb = int'(b[62:52]);
		if (eb != 0) mb[52] = 1'b1;
		else begin
			eb = 1;
			while (!mb[52]) begin mb = mb << 1; eb--; end
		end
		e = ea - eb + 1023;
		q = 64'd0; r = ma;
		for (int i = 0; i < 56; i++) begin
			if (r >= mb) begin r = r - mb; q = (q << 1) | 64'd1; end
			else q = q << 1;
			r = r << 1;
		end
		w = q | {63'd0, r != 64'd0};
		if (!w[55]) begin w = w << 1; e--; end
		if (e >= 2047) return sgn | INF_PATTERN;
		if (e >= 1) begin
			m = round_even(w);
			if (m[53]) begin m = m >> 1; e++; end
			if (e >= 2047) return sgn | INF_PATTERN;
			return sgn | (64'(e) << 52) | (m & FRAC_BITS);
		end
		s = 1 - e;
		if (s >= 63) w = 64'd1;
		else begin
			lost = w & ((64'd1 << s) - 64'd1);
			w = (w >> s) | {63'd0, lost != 64'd0};
		end
		return sgn | round_even(w);
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Send one item, with a random idle gap when idling is enabled.
	task automatic send_item(logic [63:0] a, logic [63:0] b);
		if (send_idles && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (send_idles && $urandom_range(99) < 31) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		quotient_queue.push_back(divide_pattern(a, b));
	endtask

	// Random binary64 biased toward interesting exponents and sparse fractions.
	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0: v[62:52] = 11'h7FF;
			1: v[62:52] = 11'h000;
			2: v[62:52] = 11'(1023 + $urandom_range(40) - 20);
			3: v[62:52] = 11'($urandom_range(60));
			4: v[62:52] = 11'(2046 - $urandom_range(60));
			5: v[51:0] = 52'($urandom_range(3)) << $urandom_range(51);
			default: ;
		endcase
		return v;
	endfunction

	// Receiver: random stalls when idling is enabled; check each accepted quotient against the oldest prediction.
	always @(posedge clk) begin
		logic [63:0] want;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (quotient_queue.size() == 0)
				report_mismatch($sformatf("unexpected quotient %h", m_axis_tdata));
			else begin
				want = quotient_queue.pop_front();
				if (m_axis_tdata !== want)
					report_mismatch($sformatf("quotient %h, want %h", m_axis_tdata, want));
			end
		end
		m_axis_tready <= !recv_idles || $urandom_range(99) >= 31;
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_specials();
		logic [63:0] vals[12];
		vals = '{64'h0, 64'h8000000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
			64'h7FF0000000000001, 64'hFFF8000000000123, 64'h0000000000000001,
			64'h000FFFFFFFFFFFFF, 64'h0010000000000000, 64'h7FEFFFFFFFFFFFFF,
			64'h3FF0000000000000, 64'hBFF8000000000000};
		for (int i = 0; i < 12; i += 2) send_item(vals[i], vals[(i + 5) % 12]);
		send_item(64'h0, 64'h0);
		send_item(64'h7FF0000000000000, 64'hFFF0000000000000);
		send_item(64'h7FF4000000000000, 64'h7FF0000000000001);
		send_item(64'h3FF0000000000000, 64'h7FF0000000000001);
		send_item(64'hFFF0000000000000, 64'h0);
		send_item(64'h3FF0000000000000, 64'h7FF0000000000000);
		send_item(64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001);
		send_item(64'h0000000000000001, 64'h7FEFFFFFFFFFFFFF);
		send_item(64'h0010000000000000, 64'h4000000000000000);
		send_item(64'h0000000000000003, 64'h4000000000000000);
		send_item(64'hFFFFFFFFFFFFFFFF, 64'h3FF0000000000000);
		send_item(64'h4008000000000000, 64'hC000000000000000);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_item(rand_operand(), rand_operand());
	endtask

	task automatic test_full_rate(int count);
		send_idles = 1'b0;
		recv_idles = 1'b0;
		test_random(count);
		send_idles = 1'b1;
		recv_idles = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_specials();
		test_random(900);
		test_full_rate(300);
		test_random(800);
		s_axis_tvalid <= 1'b0;
		while (quotient_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (error_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/fpdiv_pkg.sv
rtl/fpdiv_cell.sv
rtl/fpdiv_unpack.sv
rtl/fpdiv_round.sv
rtl/fp64_divider.sv
test/tb.sv
